// File: design/vgm_pkg.sv
// Shared types, phase codes, event codes and opcode constants for the stream parser.
`default_nettype none
package vgm_pkg;

	localparam int DEFAULT_SKIP_WIDTH = 32;
	localparam int SIZE_LO_WIDTH      = 24;

	// parse phase codes
	localparam logic [2:0] PH_OPCODE   = 3'd0;
	localparam logic [2:0] PH_ARGS     = 3'd1;
	localparam logic [2:0] PH_PCM_MARK = 3'd2;
	localparam logic [2:0] PH_PCM_TYPE = 3'd3;
	localparam logic [2:0] PH_PCM_SIZE = 3'd4;
	localparam logic [2:0] PH_PCM_SKIP = 3'd5;

	// event kinds
	localparam logic [1:0] EV_WRITE = 2'd0;
	localparam logic [1:0] EV_WAIT  = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;
	localparam logic [1:0] EV_BAD   = 2'd3;

	// opcodes
	localparam logic [7:0] OP_REG_WRITE = 8'h54;
	localparam logic [7:0] OP_WAIT_N    = 8'h61;
	localparam logic [7:0] OP_WAIT_735  = 8'h62;
	localparam logic [7:0] OP_WAIT_882  = 8'h63;
	localparam logic [7:0] OP_END       = 8'h66;
	localparam logic [7:0] OP_PCM_BLOCK = 8'h67;
	localparam logic [7:0] OP_B_FIRST   = 8'hB5;
	localparam logic [7:0] OP_B_LAST    = 8'hBF;
	localparam logic [7:0] OP_C_FIRST   = 8'hC0;
	localparam logic [7:0] OP_C_LAST    = 8'hC3;
	localparam logic [3:0] OP_SHORT_HI  = 4'h7;
	localparam logic [3:0] SHORT_MASK   = 4'hF;

	localparam logic [15:0] WAIT_NTSC = 16'd735;
	localparam logic [15:0] WAIT_PAL  = 16'd882;

	localparam logic [1:0] ARGS_SHORT = 2'd2;
	localparam logic [1:0] ARGS_LONG  = 2'd3;
	localparam logic [1:0] SIZE_LAST  = 2'd3;

	typedef struct packed {
		logic [2:0]               phase;
		logic [7:0]               opcode;
		logic [1:0]               arg_idx;
		logic [7:0]               held;
		logic [SIZE_LO_WIDTH-1:0] size_lo;
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  reg_addr;
		logic [7:0]  reg_data;
		logic [15:0] wait_samples;
		logic [7:0]  bad_opcode;
	} event_t;

endpackage
`default_nettype wire

// File: design/vgm_decode.sv
// Next-state and event decode for one stream byte.
`default_nettype none
module vgm_decode #(
	parameter int SKIP_WIDTH = vgm_pkg::DEFAULT_SKIP_WIDTH
) (
	input  wire vgm_pkg::parse_state_t cur,
	input  wire [SKIP_WIDTH-1:0]       skip,
	input  wire [7:0]                  stream_byte,
	output vgm_pkg::parse_state_t      nxt,
	output logic [SKIP_WIDTH-1:0]      skip_nxt,
	output logic                       emit,
	output vgm_pkg::event_t            ev
);
	import vgm_pkg::*;

	logic [1:0]        need;
	logic [1:0]        idx_inc;
	logic [31:0]       full_size;
	logic              size_over;
	logic [SKIP_WIDTH-1:0] skip_dec;

	assign need      = (cur.opcode >= OP_C_FIRST && cur.opcode <= OP_C_LAST) ?
	                   ARGS_LONG : ARGS_SHORT;
	assign idx_inc   = cur.arg_idx + 2'd1;
	assign full_size = {stream_byte, cur.size_lo};
	assign size_over = (full_size >> SKIP_WIDTH) != 32'd0;
	assign skip_dec  = (skip != '0) ? skip - 1'b1 : skip;

	always_comb begin
		nxt      = cur;
		skip_nxt = skip;
		emit     = 1'b0;
		ev       = '0;
		unique case (cur.phase)
			PH_ARGS: begin
				if (cur.arg_idx == 2'd0) begin
					nxt.held = stream_byte;
				end
				if (idx_inc < need) begin
					nxt.arg_idx = idx_inc;
				end else begin
					nxt.phase   = PH_OPCODE;
					nxt.arg_idx = 2'd0;
					if (cur.opcode == OP_REG_WRITE) begin
						emit        = 1'b1;
						ev.kind     = EV_WRITE;
						ev.reg_addr = cur.held;
						ev.reg_data = stream_byte;
					end else if (cur.opcode == OP_WAIT_N) begin
						emit            = 1'b1;
						ev.kind         = EV_WAIT;
						ev.wait_samples = {stream_byte, cur.held};
					end
				end
			end
			PH_PCM_MARK: begin
				nxt.phase = PH_PCM_TYPE;
			end
			PH_PCM_TYPE: begin
				nxt.phase   = PH_PCM_SIZE;
				nxt.arg_idx = 2'd0;
				nxt.size_lo = '0;
				skip_nxt    = '0;
			end
			PH_PCM_SIZE: begin
				if (cur.arg_idx != SIZE_LAST) begin
					nxt.size_lo[cur.arg_idx*8 +: 8] = stream_byte;
					nxt.arg_idx = idx_inc;
				end else begin
					nxt.arg_idx = 2'd0;
					skip_nxt    = size_over ? '1 : full_size[SKIP_WIDTH-1:0];
					nxt.phase   = (full_size == 32'd0) ? PH_OPCODE : PH_PCM_SKIP;
				end
			end
			PH_PCM_SKIP: begin
				skip_nxt = skip_dec;
				if (skip_dec == '0) begin
					nxt.phase = PH_OPCODE;
				end
			end
			default: begin
				// opcode position; unused phase codes land here too
				nxt.opcode  = stream_byte;
				nxt.arg_idx = 2'd0;
				priority if (stream_byte == OP_REG_WRITE || stream_byte == OP_WAIT_N ||
				             (stream_byte >= OP_B_FIRST && stream_byte <= OP_B_LAST) ||
				             (stream_byte >= OP_C_FIRST && stream_byte <= OP_C_LAST)) begin
					nxt.phase = PH_ARGS;
				end else if (stream_byte == OP_PCM_BLOCK) begin
					nxt.phase = PH_PCM_MARK;
				end else begin
					nxt.phase = PH_OPCODE;
					emit      = 1'b1;
					priority if (stream_byte == OP_WAIT_735) begin
						ev.kind         = EV_WAIT;
						ev.wait_samples = WAIT_NTSC;
					end else if (stream_byte == OP_WAIT_882) begin
						ev.kind         = EV_WAIT;
						ev.wait_samples = WAIT_PAL;
					end else if (stream_byte[7:4] == OP_SHORT_HI) begin
						ev.kind         = EV_WAIT;
						ev.wait_samples = {12'd0, stream_byte[3:0] & SHORT_MASK} + 16'd1;
					end else if (stream_byte == OP_END) begin
						ev.kind = EV_END;
					end else begin
						ev.kind       = EV_BAD;
						ev.bad_opcode = stream_byte;
					end
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/vgm_command_stream_parser.sv
// Top level of the command stream parser: input register, parse state, result register.
`default_nettype none
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------------------
//  stream   | stream_valid / stream_ready   | stream_byte
//  event    | event_valid  / event_ready    | event_kind, reg_addr, reg_data,
//           |                               | wait_samples, bad_opcode
//
//  One byte per cycle sustained while the result register is free. A byte is
//  held in the input register, decoded against the parse state, and its event
//  (if any) is registered in the result register before it appears on the outputs.
//  Reset clears the parse state to the opcode phase and both valid flags.
//  When the result register is full and not taken, decoding stalls and
//  stream_ready drops once the input register is also occupied.
//
module vgm_command_stream_parser #(
	parameter int SKIP_WIDTH = vgm_pkg::DEFAULT_SKIP_WIDTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         stream_valid,
	output logic        stream_ready,
	input  wire  [7:0]  stream_byte,
	output logic        event_valid,
	input  wire         event_ready,
	output logic [1:0]  event_kind,
	output logic [7:0]  reg_addr,
	output logic [7:0]  reg_data,
	output logic [15:0] wait_samples,
	output logic [7:0]  bad_opcode
);
	import vgm_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state and PCM skip counter
	parse_state_t          state_q;
	parse_state_t          state_nxt;
	logic [SKIP_WIDTH-1:0] skip_q;
	logic [SKIP_WIDTH-1:0] skip_nxt;

	// result register
	logic   out_valid_q;
	event_t ev_q;
	event_t ev_nxt;
	logic   emit;

	logic out_free;
	logic advance;

	// result slot can take a new event this cycle
	assign out_free     = !out_valid_q || event_ready;
	// the byte in the input register is decoded this cycle
	assign advance      = valid_s1 && out_free;
	assign stream_ready = !valid_s1 || out_free;

	vgm_decode #(
		.SKIP_WIDTH(SKIP_WIDTH)
	) u_decode (
		.cur        (state_q),
		.skip       (skip_q),
		.stream_byte(byte_s1),
		.nxt        (state_nxt),
		.skip_nxt   (skip_nxt),
		.emit       (emit),
		.ev         (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream_ready) begin
			valid_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && stream_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// all-zero state is the opcode phase
			state_q <= '0;
			skip_q  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			skip_q  <= skip_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			ev_q <= ev_nxt;
		end
	end

	assign event_valid  = out_valid_q;
	assign event_kind   = ev_q.kind;
	assign reg_addr     = ev_q.reg_addr;
	assign reg_data     = ev_q.reg_data;
	assign wait_samples = ev_q.wait_samples;
	assign bad_opcode   = ev_q.bad_opcode;

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the command stream parser: directed table, then random streams.
`default_nettype none
module testbench;
	import vgm_pkg::*;

	localparam int SKIP_W       = DEFAULT_SKIP_WIDTH;
	localparam int RAND_ITEMS   = 800;     // random bytes, PCM payload not counted
	localparam int CYCLE_LIMIT  = 200000;  // several times the slowest legal run
	localparam int DRAIN_CYCLES = 8;       // extra cycles run after the last owed event is taken
	localparam int RESET_CYCLES = 7;

	// one row of the directed table; typed rows carry the event read off by hand
	typedef struct {
		logic [7:0] b;
		bit         typed;
		event_t     ev;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        stream_valid;
	logic        stream_ready;
	logic [7:0]  stream_byte;
	logic        event_valid;
	logic        event_ready;
	logic [1:0]  event_kind;
	logic [7:0]  reg_addr;
	logic [7:0]  reg_data;
	logic [15:0] wait_samples;
	logic [7:0]  bad_opcode;

	// parser mirror: phase, opcode, argument count, first argument, PCM bytes left
	logic [2:0]  cur_phase;
	logic [7:0]  cur_op;
	logic [1:0]  arg_cnt;
	logic [7:0]  first_arg;
	logic [31:0] skip_left;

	event_t   pending_events[$];  // events still owed by the block, oldest first
	dir_row_t dir_rows[$];
	int       fail_cnt = 0;
	int       cycle_cnt = 0;
	int       sent_cnt;
	bit       tx_gaps;
	bit       rx_gaps = 1'b0;

	vgm_command_stream_parser #(
		.SKIP_WIDTH(SKIP_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream_valid(stream_valid),
		.stream_ready(stream_ready),
		.stream_byte(stream_byte),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_kind(event_kind),
		.reg_addr(reg_addr),
		.reg_data(reg_data),
		.wait_samples(wait_samples),
		.bad_opcode(bad_opcode)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic event_t mk_ev(logic [1:0] k, logic [7:0] a, logic [7:0] d,
			logic [15:0] w, logic [7:0] o);
		event_t e;
		e.kind         = k;
		e.reg_addr     = a;
		e.reg_data     = d;
		e.wait_samples = w;
		e.bad_opcode   = o;
		return e;
	endfunction

	// Advance the parser mirror by one byte; fires is set when the byte completes an event.
	task automatic decode_stream_byte(input logic [7:0] b, output bit fires, output event_t ev);
		logic [1:0]  need;
		logic [63:0] skip_cap;
		fires = 1'b0;
		ev    = '0;
		case (cur_phase)
			PH_ARGS: begin
				need = (cur_op >= OP_C_FIRST && cur_op <= OP_C_LAST) ? ARGS_LONG : ARGS_SHORT;
				if (arg_cnt == 2'd0)
					first_arg = b;
				arg_cnt = arg_cnt + 2'd1;
				if (arg_cnt >= need) begin
					cur_phase = PH_OPCODE;
					arg_cnt   = 2'd0;
					if (cur_op == OP_REG_WRITE) begin
						fires = 1'b1;
						ev    = mk_ev(EV_WRITE, first_arg, b, 16'd0, 8'd0);
					end else if (cur_op == OP_WAIT_N) begin
						fires = 1'b1;
						ev    = mk_ev(EV_WAIT, 8'd0, 8'd0, {b, first_arg}, 8'd0);
					end
					// 0xB5..0xBF and 0xC0..0xC3 end here without an event
				end
			end
			PH_PCM_MARK: cur_phase = PH_PCM_TYPE;  // marker byte is not checked
			PH_PCM_TYPE: begin
				cur_phase = PH_PCM_SIZE;
				arg_cnt   = 2'd0;
				skip_left = '0;
			end
			PH_PCM_SIZE: begin
				// little-endian 32-bit size, saturated to the skip counter width
				skip_left = skip_left | (32'(b) << (8 * arg_cnt));
				if (arg_cnt < SIZE_LAST) begin
					arg_cnt = arg_cnt + 2'd1;
				end else begin
					arg_cnt  = 2'd0;
					skip_cap = (64'd1 << SKIP_W) - 64'd1;
					if ({32'd0, skip_left} > skip_cap)
						skip_left = skip_cap[31:0];
					cur_phase = (skip_left == 32'd0) ? PH_OPCODE : PH_PCM_SKIP;
				end
			end
			PH_PCM_SKIP: begin
				if (skip_left != 32'd0)
					skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0)
					cur_phase = PH_OPCODE;
			end
			default: begin
				// opcode phase; unused phase codes fall here too
				cur_op  = b;
				arg_cnt = 2'd0;
				if (b == OP_REG_WRITE || b == OP_WAIT_N ||
						(b >= OP_B_FIRST && b <= OP_B_LAST) ||
						(b >= OP_C_FIRST && b <= OP_C_LAST)) begin
					cur_phase = PH_ARGS;
				end else if (b == OP_PCM_BLOCK) begin
					cur_phase = PH_PCM_MARK;
				end else begin
					cur_phase = PH_OPCODE;
					fires     = 1'b1;
					if (b == OP_WAIT_735)
						ev = mk_ev(EV_WAIT, 8'd0, 8'd0, WAIT_NTSC, 8'd0);
					else if (b == OP_WAIT_882)
						ev = mk_ev(EV_WAIT, 8'd0, 8'd0, WAIT_PAL, 8'd0);
					else if (b[7:4] == OP_SHORT_HI)
						ev = mk_ev(EV_WAIT, 8'd0, 8'd0, 16'(b[3:0] & SHORT_MASK) + 16'd1, 8'd0);
					else if (b == OP_END)
						ev = mk_ev(EV_END, 8'd0, 8'd0, 16'd0, 8'd0);
					else
						ev = mk_ev(EV_BAD, 8'd0, 8'd0, 16'd0, b);
				end
			end
		endcase
	endtask

	task automatic add_row(input logic [7:0] b, input bit typed = 1'b0, input event_t ev = '0);
		dir_row_t r;
		r.b     = b;
		r.typed = typed;
		r.ev    = ev;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	// Called at a falling edge; returns at the falling edge after the byte is taken.
	// A zero gap keeps valid high into the next byte with no glitch.
	task automatic send_byte(input logic [7:0] b, input bit typed, input event_t typed_ev);
		int     gap;
		bit     fires;
		event_t ev;
		if (sent_cnt % 64 == 0)
			tx_gaps = 1'($urandom_range(0, 1));
		gap = tx_gaps ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			stream_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte  <= b;
		@(posedge clk);
		while (!stream_ready)
			@(posedge clk);
		decode_stream_byte(b, fires, ev);
		if (typed)
			pending_events.insert(pending_events.size(), typed_ev);
		else if (fires)
			pending_events.insert(pending_events.size(), ev);
		sent_cnt++;
		@(negedge clk);
	endtask

	// Event sink: random stall before each event, with stall-free stretches.
	initial begin : event_sink
		int stall;
		int taken;
		taken       = 0;
		event_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 48 == 0)
				rx_gaps = 1'($urandom_range(0, 1));
			stall = rx_gaps ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				event_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			event_ready <= 1'b1;
			@(posedge clk);
			while (!(event_valid && event_ready))
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	// Compare each taken event with the oldest one owed.
	always @(posedge clk) begin : event_check
		event_t want;
		if (arst_n && event_valid && event_ready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: expected no event, actual kind=%0d addr=%h data=%h wait=%0d bad=%h",
					$time, event_kind, reg_addr, reg_data, wait_samples, bad_opcode);
				fail_cnt++;
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind || reg_addr !== want.reg_addr ||
						reg_data !== want.reg_data || wait_samples !== want.wait_samples ||
						bad_opcode !== want.bad_opcode) begin
					$display("%0t: expected kind=%0d addr=%h data=%h wait=%0d bad=%h",
						$time, want.kind, want.reg_addr, want.reg_data,
						want.wait_samples, want.bad_opcode);
					$display("%0t: actual   kind=%0d addr=%h data=%h wait=%0d bad=%h",
						$time, event_kind, reg_addr, reg_data, wait_samples, bad_opcode);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int         n_rand;
		int         pick;
		logic [7:0] nb;
		arst_n       = 1'b0;
		stream_valid = 1'b0;
		stream_byte  = 8'd0;
		sent_cnt     = 0;
		tx_gaps      = 1'b0;
		n_rand       = 0;
		cur_phase    = PH_OPCODE;
		cur_op       = 8'd0;
		arg_cnt      = 2'd0;
		first_arg    = 8'd0;
		skip_left    = 32'd0;

		// Directed table. Typed rows: single-byte events, extremes, unknown opcodes.
		add_row(OP_END, 1'b1, mk_ev(EV_END, 8'd0, 8'd0, 16'd0, 8'd0));
		add_row(OP_WAIT_735, 1'b1, mk_ev(EV_WAIT, 8'd0, 8'd0, 16'd735, 8'd0));
		add_row(OP_WAIT_882, 1'b1, mk_ev(EV_WAIT, 8'd0, 8'd0, 16'd882, 8'd0));
		add_row(8'h70, 1'b1, mk_ev(EV_WAIT, 8'd0, 8'd0, 16'd1, 8'd0));
		add_row(8'h7F, 1'b1, mk_ev(EV_WAIT, 8'd0, 8'd0, 16'd16, 8'd0));
		add_row(OP_REG_WRITE);
		add_row(8'h00);
		add_row(8'hFF, 1'b1, mk_ev(EV_WRITE, 8'h00, 8'hFF, 16'd0, 8'd0));
		// wait of zero samples
		add_row(OP_WAIT_N);
		add_row(8'h00);
		add_row(8'h00, 1'b1, mk_ev(EV_WAIT, 8'd0, 8'd0, 16'd0, 8'd0));
		add_row(OP_WAIT_N);
		add_row(8'hFF);
		add_row(8'hFF, 1'b1, mk_ev(EV_WAIT, 8'd0, 8'd0, 16'hFFFF, 8'd0));
		add_row(8'h00, 1'b1, mk_ev(EV_BAD, 8'd0, 8'd0, 16'd0, 8'h00));
		add_row(8'hFF, 1'b1, mk_ev(EV_BAD, 8'd0, 8'd0, 16'd0, 8'hFF));
		// swallowed three- and four-byte commands; args look like opcodes on purpose
		add_row(OP_B_LAST);
		add_row(OP_END);
		add_row(8'h34);
		add_row(OP_C_FIRST);
		add_row(OP_WAIT_735);
		add_row(8'h02);
		add_row(OP_END);
		// PCM block with a bogus marker and a zero size: straight back to opcodes
		add_row(OP_PCM_BLOCK);
		add_row(8'h00);
		add_row(8'hA5);
		add_row(8'h00);
		add_row(8'h00);
		add_row(8'h00);
		add_row(8'h00);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].ev);

		// Random part: the next byte is chosen from the mirrored parse phase, so
		// commands are mostly well formed and PCM sizes stay short.
		while (n_rand < RAND_ITEMS) begin
			if (cur_phase != PH_PCM_SKIP)
				n_rand++;
			case (cur_phase)
				PH_OPCODE: begin
					pick = $urandom_range(0, 99);
					if (pick < 20)
						nb = OP_REG_WRITE;
					else if (pick < 32)
						nb = OP_WAIT_N;
					else if (pick < 38)
						nb = pick[0] ? OP_WAIT_882 : OP_WAIT_735;
					else if (pick < 50)
						nb = {OP_SHORT_HI, 4'($urandom_range(0, 15))};
					else if (pick < 54)
						nb = OP_END;
					else if (pick < 62)
						nb = 8'($urandom_range(OP_B_FIRST, OP_B_LAST));
					else if (pick < 70)
						nb = 8'($urandom_range(OP_C_FIRST, OP_C_LAST));
					else if (pick < 80)
						nb = OP_PCM_BLOCK;
					else
						nb = 8'($urandom_range(0, 255));  // noise, mostly unknown opcodes
				end
				PH_PCM_SIZE: nb = (arg_cnt == 2'd0) ? 8'($urandom_range(0, 9)) : 8'h00;
				default:     nb = 8'($urandom_range(0, 255));
			endcase
			send_byte(nb, 1'b0, '0);
		end
		stream_valid <= 1'b0;

		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
